@@ hw/rtl/iabd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package iabd_pkg;

    localparam int unsigned MODE_W  = 1;
    localparam int unsigned BSIZE_W = 16;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned IDX_W   = 7;
    localparam int unsigned STEP_W  = 15;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;
    localparam logic [MODE_W-1:0] MODE_ADPCM = 1'b0;
    localparam logic [BSIZE_W-1:0] BSIZE_RESET = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODEC_MODE   = 2'd0,
        CFG_BLOCK_SIZE   = 2'd1,
        CFG_SAMPLE_COUNT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic signed [15:0] pred;
        logic [IDX_W-1:0]   idx;
    } t_adpcm_state;

    function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        begin
            unique case (idx)
                7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
                7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
                7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
                7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
                7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
                7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
                7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
                7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
                7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
                7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
                7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
                7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
                7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
                7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
                7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
                7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
                7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
                7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
                7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
                7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
                7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
                7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
                7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
                7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
                7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
                7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
                7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
                7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
                7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
                7'd87: s = 15'd29794;
                default: s = 15'd32767;
            endcase
            return s;
        end
    endfunction

    function automatic logic signed [4:0] index_adjust(input logic [2:0] code);
        logic signed [4:0] a;
        begin
            unique case (code)
                3'd4:    a = 5'sd2;
                3'd5:    a = 5'sd4;
                3'd6:    a = 5'sd6;
                3'd7:    a = 5'sd8;
                default: a = -5'sd1;
            endcase
            return a;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/iabd_nibble.sv @@
`timescale 1ns / 1ps
`default_nettype none

module iabd_nibble (
    input  iabd_pkg::t_adpcm_state i_state,
    input  logic [3:0]             i_nib,
    output iabd_pkg::t_adpcm_state o_state
);
    import iabd_pkg::*;

    logic [IDX_W-1:0]  idx_cl;
    logic [STEP_W-1:0] step;
    logic [16:0]       delta;
    logic signed [18:0] sum;
    logic signed [18:0] dsig;
    logic signed [8:0] ni;

    always_comb begin
        idx_cl = (i_state.idx > IDX_MAX) ? IDX_MAX : i_state.idx;
        step   = step_size(idx_cl);
        delta  = {5'd0, step[STEP_W-1:3]};
        if (i_nib[2]) delta = delta + {2'd0, step};
        if (i_nib[1]) delta = delta + {3'd0, step[STEP_W-1:1]};
        if (i_nib[0]) delta = delta + {4'd0, step[STEP_W-1:2]};
        dsig = i_nib[3] ? -$signed({2'b00, delta}) : $signed({2'b00, delta});
        sum  = {{3{i_state.pred[15]}}, i_state.pred} + dsig;

        if (sum < -19'sd32768) begin
            o_state.pred = -16'sd32768;
        end else if (sum > 19'sd32767) begin
            o_state.pred = 16'sd32767;
        end else begin
            o_state.pred = sum[15:0];
        end

        ni = $signed({2'b00, idx_cl}) + 9'(index_adjust(i_nib[2:0]));
        if (ni < 9'sd0) begin
            o_state.idx = '0;
        end else if (ni > $signed({2'b00, IDX_MAX})) begin
            o_state.idx = IDX_MAX;
        end else begin
            o_state.idx = ni[IDX_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ima_adpcm_block_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Word
// input     in         i_valid / o_stall        i_data_byte, i_start_of_file
// output    out        o_valid / i_stall        o_sample, o_last_of_byte, o_end_of_track
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A byte is held in a work register and decoded one nibble per cycle, unless the
// output stalls, by a single nibble unit: an ADPCM data byte yields its low nibble
// then its high one, or just the low one if that ends the track; others are taken whole.
// Results pass through one output register; the work stage waits only when it
// has a result and that register is full and stalled.
// Synchronous active-low reset; config registers return to mode 0, block 256, count 1.

module ima_adpcm_block_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_start_of_file,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [15:0]                  o_sample,
    output logic                                o_last_of_byte,
    output logic                                o_end_of_track,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [iabd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [iabd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import iabd_pkg::*;

    logic [MODE_W-1:0]  r_codec_mode;
    logic [BSIZE_W-1:0] r_block_size;
    logic [COUNT_W-1:0] r_sample_count;

    t_adpcm_state       r_st, n_st, nib_st;
    logic [BSIZE_W-1:0] r_pos, n_pos;
    logic [7:0]         r_hdr, n_hdr;
    logic [COUNT_W-1:0] r_cnt, n_cnt;

    logic               r_w_valid;
    logic [7:0]         r_w_byte;
    logic               r_w_sof;
    logic               r_phase, n_phase;

    logic               r_out_valid;
    logic signed [15:0] r_out_sample;
    logic               r_out_last;
    logic               r_out_eot;

    logic               emit;
    logic signed [15:0] res_sample;
    logic               res_last;
    logic               res_eot;
    logic               out_free;
    logic               go;
    logic               fin;
    logic [BSIZE_W-1:0] pos_eff;
    logic [COUNT_W-1:0] cnt_eff;
    logic [COUNT_W-1:0] cnt_inc;
    logic [BSIZE_W:0]   pos_inc;
    logic [3:0]         nib;

    assign nib = r_phase ? r_w_byte[7:4] : r_w_byte[3:0];

    iabd_nibble u_nibble (
        .i_state (r_st),
        .i_nib   (nib),
        .o_state (nib_st)
    );

    always_comb begin
        n_st       = r_st;
        n_pos      = r_pos;
        n_hdr      = r_hdr;
        n_cnt      = r_cnt;
        n_phase    = 1'b0;
        emit       = 1'b0;
        res_sample = r_st.pred;
        res_last   = 1'b1;
        res_eot    = 1'b0;
        pos_eff    = r_w_sof ? '0 : r_pos;
        cnt_eff    = r_w_sof ? '0 : r_cnt;
        cnt_inc    = (r_phase ? r_cnt : cnt_eff) + COUNT_W'(1);
        pos_inc    = {1'b0, pos_eff} + (BSIZE_W+1)'(1);

        if (r_phase) begin
            n_st       = nib_st;
            n_cnt      = cnt_inc;
            emit       = 1'b1;
            res_sample = nib_st.pred;
            res_eot    = (cnt_inc == r_sample_count);
        end else begin
            n_pos = pos_eff;
            n_cnt = cnt_eff;
            if (cnt_eff >= r_sample_count) begin
                n_cnt = cnt_eff;
            end else if (r_codec_mode != MODE_ADPCM) begin
                emit       = 1'b1;
                res_sample = {~r_w_byte[7], r_w_byte[6:0], 8'h00};
                res_eot    = (cnt_inc == r_sample_count);
                n_cnt      = cnt_inc;
            end else begin
                priority if (pos_eff == BSIZE_W'(0)) begin
                    n_hdr = r_w_byte;
                end else if (pos_eff == BSIZE_W'(1)) begin
                    n_st.pred  = {r_w_byte, r_hdr};
                    n_cnt      = cnt_inc;
                    emit       = 1'b1;
                    res_sample = {r_w_byte, r_hdr};
                    res_eot    = (cnt_inc == r_sample_count);
                end else if (pos_eff == BSIZE_W'(2)) begin
                    n_st.idx = (r_w_byte > {1'b0, IDX_MAX}) ? IDX_MAX : r_w_byte[IDX_W-1:0];
                end else if (pos_eff >= BSIZE_W'(4)) begin
                    n_st       = nib_st;
                    n_cnt      = cnt_inc;
                    emit       = 1'b1;
                    res_sample = nib_st.pred;
                    if (cnt_inc >= r_sample_count) begin
                        res_eot = (cnt_inc == r_sample_count);
                    end else begin
                        res_last = 1'b0;
                        n_phase  = 1'b1;
                    end
                end else begin
                    n_hdr = r_hdr;
                end
                n_pos = (pos_inc >= {1'b0, r_block_size}) ? '0 : pos_inc[BSIZE_W-1:0];
            end
        end
    end

    assign out_free    = !r_out_valid || !i_stall;
    assign go          = r_w_valid && (!emit || out_free);
    assign fin         = go && !n_phase;
    assign o_stall     = r_w_valid && !fin;
    assign o_cfg_ready = 1'b1;

    assign o_valid        = r_out_valid;
    assign o_sample       = r_out_sample;
    assign o_last_of_byte = r_out_last;
    assign o_end_of_track = r_out_eot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec_mode   <= MODE_ADPCM;
            r_block_size   <= BSIZE_RESET;
            r_sample_count <= COUNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CODEC_MODE:   r_codec_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_BLOCK_SIZE:   r_block_size   <= i_cfg_data[BSIZE_W-1:0];
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= '0;
            r_pos     <= '0;
            r_hdr     <= '0;
            r_cnt     <= '0;
            r_phase   <= 1'b0;
            r_w_valid <= 1'b0;
        end else begin
            if (go) begin
                r_st    <= n_st;
                r_pos   <= n_pos;
                r_hdr   <= n_hdr;
                r_cnt   <= n_cnt;
                r_phase <= n_phase;
            end
            if (i_valid && !o_stall) begin
                r_w_valid <= 1'b1;
            end else if (fin) begin
                r_w_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_w_byte <= i_data_byte;
            r_w_sof  <= i_start_of_file;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= go && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && go && emit) begin
            r_out_sample <= res_sample;
            r_out_last   <= res_last;
            r_out_eot    <= res_eot;
        end
    end

`ifndef SYNTHESIS
    a_phase_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_w_valid && r_codec_mode == MODE_ADPCM))
        else $error("high nibble pending without an ADPCM byte in work");

    a_eot_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_track) |-> o_last_of_byte)
        else $error("end of track on a sample that is not last of its byte");

    a_low_then_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && n_phase) |=> (r_phase && $stable(r_w_byte)))
        else $error("low nibble not followed by high nibble of the same byte");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> (r_st.idx <= IDX_MAX))
        else $error("step index out of range");
`endif

endmodule

`default_nettype wire
